@@ rtl/cp2rgb_pkg.sv @@
// Shared types, constants and pixel arithmetic for the camera pixel to RGB888 converter.
package cp2rgb_pkg;

   // Frame limits and field widths
   localparam int MAX_WIDTH   = 4096;
   localparam int MAX_HEIGHT  = 4096;
   localparam int WORDS_CAP   = 4096;
   localparam int DIM_W       = 13;
   localparam int STRIDE_W    = 15;
   localparam int CSR_W       = 15;
   localparam int CSR_IDX_W   = 2;
   localparam int WIL_W       = $clog2(WORDS_CAP);
   localparam int WPL_W       = $clog2(WORDS_CAP) + 1;
   localparam int LINE_W      = $clog2(MAX_HEIGHT);
   localparam int PC_W        = 25;

   // Word queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH) + 1;

   // YUV arithmetic widths
   localparam int PROD_W      = 18;
   localparam int SUM_W       = 20;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_PIXEL_FORMAT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_WIDTH  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_HEIGHT = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_LINE_STRIDE  = 2'd3;

   // Pixel count codes
   localparam logic [1:0] PIX_ONE = 2'd1;
   localparam logic [1:0] PIX_TWO = 2'd2;

   typedef enum logic [1:0] {
      FMT_RGB565 = 2'd0,
      FMT_YUYV   = 2'd1,
      FMT_UYVY   = 2'd2
   } fmt_type;

   typedef enum logic {
      KIND_RGB565 = 1'b0,
      KIND_YUV    = 1'b1
   } kind_type;

   localparam fmt_type            RST_PIXEL_FORMAT = FMT_RGB565;
   localparam logic [DIM_W-1:0]    RST_FRAME_WIDTH  = 13'd1024;
   localparam logic [DIM_W-1:0]    RST_FRAME_HEIGHT = 13'd600;
   localparam logic [STRIDE_W-1:0] RST_LINE_STRIDE  = 15'd2048;

   typedef struct packed {
      fmt_type             pixel_format;
      logic [DIM_W-1:0]    frame_width;
      logic [DIM_W-1:0]    frame_height;
      logic [STRIDE_W-1:0] line_stride_bytes;
   } cfg_type;

   // One classified word. RGB565: lo0 hi0 lo1 hi1. YUV: Y0 U Y1 V.
   typedef struct packed {
      kind_type        kind;
      logic [1:0]      pixels_valid;
      logic            last;
      logic [3:0][7:0] bytes;
   } entry_type;

   // 5-bit field to 8 bits: v*255/31 = 8v + floor(7v/31)
   function automatic logic [7:0] scale5(input logic [4:0] v);
      logic [2:0] frac;
      frac = 3'(v >= 5'd5) + 3'(v >= 5'd9) + 3'(v >= 5'd14) + 3'(v >= 5'd18)
           + 3'(v >= 5'd23) + 3'(v >= 5'd27) + 3'(v == 5'd31);
      return {v, 3'b000} + 8'(frac);
   endfunction

   // 6-bit field to 8 bits: v*255/63 = 4v + floor(v/21)
   function automatic logic [7:0] scale6(input logic [5:0] v);
      logic [1:0] frac;
      frac = 2'(v >= 6'd21) + 2'(v >= 6'd42) + 2'(v == 6'd63);
      return {v, 2'b00} + 8'(frac);
   endfunction

   // Drop the eight fraction bits and clamp to 0..255
   function automatic logic [7:0] clamp_shift(input logic signed [SUM_W-1:0] s);
      logic [7:0] r;
      if (s[SUM_W-1]) begin
         r = 8'd0;
      end else if (|s[SUM_W-2:16]) begin
         r = 8'hFF;
      end else begin
         r = s[15:8];
      end
      return r;
   endfunction

endpackage

@@ rtl/camera_pixel_to_rgb888.sv @@
// Top level of the camera pixel to RGB888 converter: registers, front end, queue, back end.
//
//   channel  dir  handshake                       word contents
//   req      in   req_valid / req_ready           req_byte0..3, req_only_low_half
//   rsp      out  rsp_valid / rsp_ready           two RGB888 pixels, count, last flag
//   csr      in   csr_write_enable, no wait       csr_index, csr_wdata
//
// One word is taken per cycle while the queue has room; the front end tracks line and frame
// position for each word, and the back end is a two-stage pipeline.
// A result passes through the queue, the product stage and the output register to reach rsp.
// A four-entry queue parts front and back, so the front keeps taking words while a
// result waits on rsp_ready; req_ready drops only when that queue is full.
// Reset is synchronous; it restores register defaults and clears the frame counters.
// Any register write restarts the frame counters.
module camera_pixel_to_rgb888 (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [7:0]                          req_byte0,
   input  logic [7:0]                          req_byte1,
   input  logic [7:0]                          req_byte2,
   input  logic [7:0]                          req_byte3,
   input  logic                                req_only_low_half,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [7:0]                          rsp_red0,
   output logic [7:0]                          rsp_green0,
   output logic [7:0]                          rsp_blue0,
   output logic [7:0]                          rsp_red1,
   output logic [7:0]                          rsp_green1,
   output logic [7:0]                          rsp_blue1,
   output logic [1:0]                          rsp_pixels_valid,
   output logic                                rsp_last_of_frame,
   input  logic                                csr_write_enable,
   input  logic [cp2rgb_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [cp2rgb_pkg::CSR_W-1:0]        csr_wdata
);
   import cp2rgb_pkg::*;

   cfg_type   cfg_ff, cfg_in;
   logic      queue_full;
   logic      push;
   entry_type push_entry;
   logic      q_valid;
   logic      q_ready;
   entry_type q_entry;

   // Register file: decode the index, keep only each register's own bits
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_PIXEL_FORMAT: cfg_in.pixel_format      = fmt_type'(csr_wdata[1:0]);
            CSR_FRAME_WIDTH:  cfg_in.frame_width       = csr_wdata[DIM_W-1:0];
            CSR_FRAME_HEIGHT: cfg_in.frame_height      = csr_wdata[DIM_W-1:0];
            CSR_LINE_STRIDE:  cfg_in.line_stride_bytes = csr_wdata[STRIDE_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pixel_format      <= RST_PIXEL_FORMAT;
         cfg_ff.frame_width       <= RST_FRAME_WIDTH;
         cfg_ff.frame_height      <= RST_FRAME_HEIGHT;
         cfg_ff.line_stride_bytes <= RST_LINE_STRIDE;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Front: take each word, advance the frame position, drop padding and unused formats
   cp2rgb_front u_front (
      .clock             (clock),
      .reset             (reset),
      .cfg               (cfg_ff),
      .restart           (csr_write_enable),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_byte0         (req_byte0),
      .req_byte1         (req_byte1),
      .req_byte2         (req_byte2),
      .req_byte3         (req_byte3),
      .req_only_low_half (req_only_low_half),
      .queue_full        (queue_full),
      .push              (push),
      .push_entry        (push_entry)
   );

   // Queue: hold classified words while the back end stalls
   cp2rgb_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (queue_full),
      .pop_valid  (q_valid),
      .pop_ready  (q_ready),
      .pop_entry  (q_entry)
   );

   // Back: scale RGB565 fields or convert the 4:2:2 group, then present the result
   cp2rgb_back u_back (
      .clock             (clock),
      .reset             (reset),
      .q_valid           (q_valid),
      .q_ready           (q_ready),
      .q_entry           (q_entry),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_red0          (rsp_red0),
      .rsp_green0        (rsp_green0),
      .rsp_blue0         (rsp_blue0),
      .rsp_red1          (rsp_red1),
      .rsp_green1        (rsp_green1),
      .rsp_blue1         (rsp_blue1),
      .rsp_pixels_valid  (rsp_pixels_valid),
      .rsp_last_of_frame (rsp_last_of_frame)
   );

endmodule

@@ rtl/cp2rgb_front.sv @@
// Front end: accepts source words, tracks frame position and classifies each word.
module cp2rgb_front (
   input  logic                  clock,
   input  logic                  reset,
   input  cp2rgb_pkg::cfg_type   cfg,
   input  logic                  restart,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [7:0]            req_byte0,
   input  logic [7:0]            req_byte1,
   input  logic [7:0]            req_byte2,
   input  logic [7:0]            req_byte3,
   input  logic                  req_only_low_half,
   input  logic                  queue_full,
   output logic                  push,
   output cp2rgb_pkg::entry_type push_entry
);
   import cp2rgb_pkg::*;

   logic [DIM_W-1:0]    width_c;
   logic [DIM_W-1:0]    height_c;
   logic [2*DIM_W-1:0]  area;
   logic [PC_W-1:0]     total;
   logic [WIL_W-1:0]    valid_words;
   logic [WPL_W-1:0]    wpl_raw;
   logic [WPL_W-1:0]    wpl;

   logic [WIL_W-1:0]    wil_ff, wil_in;
   logic [LINE_W-1:0]   lc_ff, lc_in;
   logic [PC_W-1:0]     pc_ff, pc_in;

   logic [WIL_W:0]      wil_inc;
   logic [LINE_W:0]     lc_inc;
   logic                line_done;
   logic                frame_done;
   logic                emit_yuv;
   logic                last_yuv;
   logic [PC_W-1:0]     remaining;
   logic                one_pix;
   logic [PC_W-1:0]     pc_sum;
   logic                rgb_last;
   logic                accept;

   // Clamp the frame size
   assign width_c  = (cfg.frame_width == '0) ? DIM_W'(1) :
                     (cfg.frame_width > DIM_W'(MAX_WIDTH)) ? DIM_W'(MAX_WIDTH) :
                     cfg.frame_width;
   assign height_c = (cfg.frame_height == '0) ? DIM_W'(1) :
                     (cfg.frame_height > DIM_W'(MAX_HEIGHT)) ? DIM_W'(MAX_HEIGHT) :
                     cfg.frame_height;

   assign area  = width_c * height_c;
   assign total = area[PC_W-1:0];

   // Words per source line: stride, at least the pixel words, 1..WORDS_CAP
   assign valid_words = width_c[DIM_W-1:1];
   assign wpl_raw = (WPL_W'(cfg.line_stride_bytes[STRIDE_W-1:2]) < WPL_W'(valid_words)) ?
                    WPL_W'(valid_words) : WPL_W'(cfg.line_stride_bytes[STRIDE_W-1:2]);
   assign wpl = (wpl_raw == '0) ? WPL_W'(1) :
                (wpl_raw > WPL_W'(WORDS_CAP)) ? WPL_W'(WORDS_CAP) : wpl_raw;

   assign wil_inc    = {1'b0, wil_ff} + (WIL_W+1)'(1);
   assign lc_inc     = {1'b0, lc_ff} + (LINE_W+1)'(1);
   assign line_done  = wil_inc >= wpl;
   assign frame_done = lc_inc >= height_c;
   assign emit_yuv   = wil_ff < valid_words;
   assign last_yuv   = emit_yuv && (lc_inc == height_c) &&
                       (wil_inc == (WIL_W+1)'(valid_words));

   assign remaining = total - pc_ff;
   assign one_pix   = req_only_low_half || (remaining == PC_W'(1));
   assign pc_sum    = pc_ff + (one_pix ? PC_W'(1) : PC_W'(2));
   assign rgb_last  = pc_sum >= total;

   assign req_ready = !queue_full;
   assign accept    = req_valid && req_ready;

   always_comb begin
      wil_in = wil_ff;
      lc_in  = lc_ff;
      pc_in  = pc_ff;
      push   = 1'b0;
      push_entry.kind         = KIND_RGB565;
      push_entry.pixels_valid = one_pix ? PIX_ONE : PIX_TWO;
      push_entry.last         = rgb_last;
      push_entry.bytes        = {req_byte3, req_byte2, req_byte1, req_byte0};

      case (cfg.pixel_format)
         FMT_YUYV: begin
            push_entry.kind         = KIND_YUV;
            push_entry.pixels_valid = PIX_TWO;
            push_entry.last         = last_yuv;
         end
         FMT_UYVY: begin
            push_entry.kind         = KIND_YUV;
            push_entry.pixels_valid = PIX_TWO;
            push_entry.last         = last_yuv;
            push_entry.bytes        = {req_byte2, req_byte3, req_byte0, req_byte1};
         end
         default: ;
      endcase

      if (restart) begin
         wil_in = '0;
         lc_in  = '0;
         pc_in  = '0;
      end else if (accept) begin
         case (cfg.pixel_format)
            FMT_RGB565: begin
               push  = 1'b1;
               pc_in = rgb_last ? '0 : pc_sum;
            end
            FMT_YUYV, FMT_UYVY: begin
               // padding words advance the position but carry no pixels
               push = emit_yuv;
               if (line_done) begin
                  wil_in = '0;
                  lc_in  = frame_done ? '0 : lc_inc[LINE_W-1:0];
               end else begin
                  wil_in = wil_inc[WIL_W-1:0];
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wil_ff <= '0;
         lc_ff  <= '0;
         pc_ff  <= '0;
      end else begin
         wil_ff <= wil_in;
         lc_ff  <= lc_in;
         pc_ff  <= pc_in;
      end
   end

   a_rgb_count_in_frame: assert property (@(posedge clock) disable iff (reset)
      cfg.pixel_format == FMT_RGB565 |-> pc_ff < total)
      else $error("RGB565 pixel count reached frame size");

   a_yuv_position_in_frame: assert property (@(posedge clock) disable iff (reset)
      (cfg.pixel_format == FMT_YUYV || cfg.pixel_format == FMT_UYVY)
      |-> ({1'b0, wil_ff} < wpl && {1'b0, lc_ff} < height_c))
      else $error("YUV word or line position out of frame");

endmodule

@@ rtl/cp2rgb_queue.sv @@
// Short word queue between the classifying front end and the pixel back end.
module cp2rgb_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  cp2rgb_pkg::entry_type push_entry,
   output logic                  full,
   output logic                  pop_valid,
   input  logic                  pop_ready,
   output cp2rgb_pkg::entry_type pop_entry
);
   import cp2rgb_pkg::*;

   entry_type           slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;
   logic                pop;

   assign full      = count_ff == QCNT_W'(QUEUE_DEPTH);
   assign pop_valid = count_ff != '0;
   assign pop       = pop_valid && pop_ready;
   assign pop_entry = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      push |-> !full)
      else $error("word pushed into a full queue");

   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QCNT_W'(QUEUE_DEPTH))
      else $error("queue count above depth");

endmodule

@@ rtl/cp2rgb_back.sv @@
// Back end: turns classified words into RGB888 pixel pairs over two pipeline stages.
module cp2rgb_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  q_valid,
   output logic                  q_ready,
   input  cp2rgb_pkg::entry_type q_entry,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [7:0]            rsp_red0,
   output logic [7:0]            rsp_green0,
   output logic [7:0]            rsp_blue0,
   output logic [7:0]            rsp_red1,
   output logic [7:0]            rsp_green1,
   output logic [7:0]            rsp_blue1,
   output logic [1:0]            rsp_pixels_valid,
   output logic                  rsp_last_of_frame
);
   import cp2rgb_pkg::*;

   // Stage 1: RGB565 scaling done, YUV products registered
   logic                      s1_valid_ff, s1_valid_in;
   kind_type                  s1_kind_ff;
   logic [1:0]                s1_pix_ff;
   logic                      s1_last_ff;
   logic [5:0][7:0]           s1_rgb_ff, s1_rgb_in;
   logic signed [PROD_W-1:0]  c0_298_ff, c1_298_ff, e_409_ff, d_100_ff, e_208_ff, d_516_ff;
   logic signed [PROD_W-1:0]  c0_298_in, c1_298_in, e_409_in, d_100_in, e_208_in, d_516_in;

   // Output register
   logic                      out_valid_ff, out_valid_in;
   logic [5:0][7:0]           out_rgb_ff, out_rgb_in;
   logic [1:0]                out_pix_ff;
   logic                      out_last_ff;

   logic                      s1_ready;
   logic                      out_ready;
   logic                      load_s1;
   logic                      load_out;

   logic [15:0]               px0, px1;
   logic signed [8:0]         c0, c1;
   logic signed [7:0]         d, e;
   logic signed [SUM_W-1:0]   sum_r0, sum_g0, sum_b0, sum_r1, sum_g1, sum_b1;

   assign out_ready = !out_valid_ff || rsp_ready;
   assign s1_ready  = !s1_valid_ff || out_ready;
   assign q_ready   = s1_ready;
   assign load_s1   = s1_ready && q_valid;
   assign load_out  = out_ready && s1_valid_ff;

   // Stage 1 datapath
   always_comb begin
      px0 = {q_entry.bytes[1], q_entry.bytes[0]};
      px1 = {q_entry.bytes[3], q_entry.bytes[2]};
      s1_rgb_in[0] = scale5(px0[15:11]);
      s1_rgb_in[1] = scale6(px0[10:5]);
      s1_rgb_in[2] = scale5(px0[4:0]);
      s1_rgb_in[3] = scale5(px1[15:11]);
      s1_rgb_in[4] = scale6(px1[10:5]);
      s1_rgb_in[5] = scale5(px1[4:0]);
      // zero the second pixel of a single-pixel word
      if (q_entry.pixels_valid == PIX_ONE) begin
         s1_rgb_in[3] = '0;
         s1_rgb_in[4] = '0;
         s1_rgb_in[5] = '0;
      end

      c0 = $signed({1'b0, q_entry.bytes[0]}) - 9'sd16;
      c1 = $signed({1'b0, q_entry.bytes[2]}) - 9'sd16;
      d  = $signed({~q_entry.bytes[1][7], q_entry.bytes[1][6:0]});
      e  = $signed({~q_entry.bytes[3][7], q_entry.bytes[3][6:0]});

      c0_298_in = PROD_W'(c0) * 18'sd298;
      c1_298_in = PROD_W'(c1) * 18'sd298;
      e_409_in  = PROD_W'(e) * 18'sd409;
      d_100_in  = PROD_W'(d) * 18'sd100;
      e_208_in  = PROD_W'(e) * 18'sd208;
      d_516_in  = PROD_W'(d) * 18'sd516;
   end

   // Stage 2 datapath: sums, rounding and clamp
   always_comb begin
      sum_r0 = SUM_W'(c0_298_ff) + SUM_W'(e_409_ff) + 20'sd128;
      sum_g0 = SUM_W'(c0_298_ff) - SUM_W'(d_100_ff) - SUM_W'(e_208_ff) + 20'sd128;
      sum_b0 = SUM_W'(c0_298_ff) + SUM_W'(d_516_ff) + 20'sd128;
      sum_r1 = SUM_W'(c1_298_ff) + SUM_W'(e_409_ff) + 20'sd128;
      sum_g1 = SUM_W'(c1_298_ff) - SUM_W'(d_100_ff) - SUM_W'(e_208_ff) + 20'sd128;
      sum_b1 = SUM_W'(c1_298_ff) + SUM_W'(d_516_ff) + 20'sd128;
      if (s1_kind_ff == KIND_YUV) begin
         out_rgb_in[0] = clamp_shift(sum_r0);
         out_rgb_in[1] = clamp_shift(sum_g0);
         out_rgb_in[2] = clamp_shift(sum_b0);
         out_rgb_in[3] = clamp_shift(sum_r1);
         out_rgb_in[4] = clamp_shift(sum_g1);
         out_rgb_in[5] = clamp_shift(sum_b1);
      end else begin
         out_rgb_in = s1_rgb_ff;
      end
   end

   assign s1_valid_in  = s1_ready ? q_valid : s1_valid_ff;
   assign out_valid_in = out_ready ? s1_valid_ff : out_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_s1) begin
         s1_kind_ff <= q_entry.kind;
         s1_pix_ff  <= q_entry.pixels_valid;
         s1_last_ff <= q_entry.last;
         s1_rgb_ff  <= s1_rgb_in;
         c0_298_ff  <= c0_298_in;
         c1_298_ff  <= c1_298_in;
         e_409_ff   <= e_409_in;
         d_100_ff   <= d_100_in;
         e_208_ff   <= e_208_in;
         d_516_ff   <= d_516_in;
      end
      if (load_out) begin
         out_rgb_ff  <= out_rgb_in;
         out_pix_ff  <= s1_pix_ff;
         out_last_ff <= s1_last_ff;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_red0          = out_rgb_ff[0];
   assign rsp_green0        = out_rgb_ff[1];
   assign rsp_blue0         = out_rgb_ff[2];
   assign rsp_red1          = out_rgb_ff[3];
   assign rsp_green1        = out_rgb_ff[4];
   assign rsp_blue1         = out_rgb_ff[5];
   assign rsp_pixels_valid  = out_pix_ff;
   assign rsp_last_of_frame = out_last_ff;

   a_pixel_count_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_pixels_valid == PIX_ONE || rsp_pixels_valid == PIX_TWO))
      else $error("result carries neither one nor two pixels");

   a_single_pixel_zeroed: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_pixels_valid == PIX_ONE)
      |-> (rsp_red1 == 8'd0 && rsp_green1 == 8'd0 && rsp_blue1 == 8'd0))
      else $error("second pixel not cleared on a single-pixel result");

   a_yuv_two_pixels: assert property (@(posedge clock) disable iff (reset)
      (load_out && s1_kind_ff == KIND_YUV) |=> rsp_pixels_valid == PIX_TWO)
      else $error("YUV group produced fewer than two pixels");

endmodule

@@ tb/tb_camera_pixel_to_rgb888.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for the camera pixel to RGB888 converter, driven by directed and random words.
module tb_camera_pixel_to_rgb888;
   import cp2rgb_pkg::*;

   localparam int CYCLE_LIMIT  = 400000;
   localparam int DRAIN_CYCLES = 8;     // idle time after the last result, before new settings
   localparam int RANDOM_WORDS = 840;
   localparam int PRESSURE_WORDS = 40;  // words offered during the long receiver hold-off
   localparam int PRESSURE_LEN = 300;
   localparam int PRINT_CAP    = 50;
   localparam logic [1:0] FMT_UNUSED = 2'd3;
   localparam logic [3:0] ALL_REGS   = 4'hF;

   typedef struct packed {
      logic [7:0] byte0;
      logic [7:0] byte1;
      logic [7:0] byte2;
      logic [7:0] byte3;
      logic       only_low_half;
   } camera_word_type;

   typedef struct packed {
      logic [7:0] red0;
      logic [7:0] green0;
      logic [7:0] blue0;
      logic [7:0] red1;
      logic [7:0] green1;
      logic [7:0] blue1;
      logic [1:0] pixels_valid;
      logic       last_of_frame;
   } rgb_pair_type;

   // Block inputs start at known values
   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic [7:0]           req_byte0 = 8'd0;
   logic [7:0]           req_byte1 = 8'd0;
   logic [7:0]           req_byte2 = 8'd0;
   logic [7:0]           req_byte3 = 8'd0;
   logic                 req_only_low_half = 1'b0;
   logic                 rsp_ready = 1'b0;
   logic                 csr_write_enable = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_W-1:0]     csr_wdata = '0;

   logic                 req_ready;
   logic                 rsp_valid;
   logic [7:0]           rsp_red0, rsp_green0, rsp_blue0;
   logic [7:0]           rsp_red1, rsp_green1, rsp_blue1;
   logic [1:0]           rsp_pixels_valid;
   logic                 rsp_last_of_frame;

   // Predictor copy of the registers and the frame counters
   logic [1:0]           cfg_fmt    = 2'd0;
   logic [DIM_W-1:0]     cfg_width  = RST_FRAME_WIDTH;
   logic [DIM_W-1:0]     cfg_height = RST_FRAME_HEIGHT;
   logic [STRIDE_W-1:0]  cfg_stride = RST_LINE_STRIDE;
   logic [WIL_W-1:0]     word_pos   = '0;
   logic [LINE_W-1:0]    line_pos   = '0;
   logic [PC_W-1:0]      pix_count  = '0;

   camera_word_type      pending_words[$];
   rgb_pair_type         expected_pairs[$];

   int                   cycle_count = 0;
   int                   error_count = 0;
   int                   words_taken = 0;
   int                   results_checked = 0;
   int                   frame_ends = 0;
   int                   settings_count = 0;
   int                   send_gap = 0;
   int                   rsp_hold = 0;
   bit                   pressure_go = 1'b0;
   bit                   pressure_done = 1'b0;
   logic                 req_took = 1'b0;
   logic                 quiet_window;

   camera_word_type      next_word;
   camera_word_type      taken_word;
   rgb_pair_type         got_pair;
   rgb_pair_type         want_pair;
   logic                 produced;
   rgb_pair_type         made_pair;

   camera_pixel_to_rgb888 dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_byte0         (req_byte0),
      .req_byte1         (req_byte1),
      .req_byte2         (req_byte2),
      .req_byte3         (req_byte3),
      .req_only_low_half (req_only_low_half),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_red0          (rsp_red0),
      .rsp_green0        (rsp_green0),
      .rsp_blue0         (rsp_blue0),
      .rsp_red1          (rsp_red1),
      .rsp_green1        (rsp_green1),
      .rsp_blue1         (rsp_blue1),
      .rsp_pixels_valid  (rsp_pixels_valid),
      .rsp_last_of_frame (rsp_last_of_frame),
      .csr_write_enable  (csr_write_enable),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Hold both sides busy, with no random gaps, whenever cycle_count[8:7] is 2'b11
   assign quiet_window = (cycle_count[8:7] == 2'b11);

   // Count cycles and give up at the limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb_camera_pixel_to_rgb888: FAIL");
         $finish;
      end
   end

   // Mostly no gap, sometimes a short one, rarely a long one
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 70) return 0;
      if (roll < 95) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic logic [7:0] pick_byte();
      case ($urandom_range(0, 15))
         0: return 8'h00;
         1: return 8'hFF;
         default: return 8'($urandom);
      endcase
   endfunction

   function automatic camera_word_type random_word();
      camera_word_type wd;
      wd.byte0 = pick_byte();
      wd.byte1 = pick_byte();
      wd.byte2 = pick_byte();
      wd.byte3 = pick_byte();
      wd.only_low_half = ($urandom_range(0, 3) == 0);
      return wd;
   endfunction

   // Drop the fraction and clamp to a byte
   function automatic logic [7:0] clip_to_byte(input int s);
      if (s < 0) return 8'h00;
      if ((s >>> 8) > 255) return 8'hFF;
      return 8'(s >>> 8);
   endfunction

   // BT.601 integer conversion of one pixel, packed as {R, G, B}
   function automatic logic [23:0] bt601_pixel(input logic [7:0] y, u, v);
      int c, d, e;
      c = int'(y) - 16;
      d = int'(u) - 128;
      e = int'(v) - 128;
      return {clip_to_byte(298 * c + 409 * e + 128),
              clip_to_byte(298 * c - 100 * d - 208 * e + 128),
              clip_to_byte(298 * c + 516 * d + 128)};
   endfunction

   // Little-endian 5/6/5 pixel scaled to 8 bits per channel
   function automatic logic [23:0] rgb565_to_rgb(input logic [7:0] lo, hi);
      logic [15:0] p;
      int r, g, b;
      p = {hi, lo};
      r = int'(p[15:11]) * 255 / 31;
      g = int'(p[10:5]) * 255 / 63;
      b = int'(p[4:0]) * 255 / 31;
      return {8'(r), 8'(g), 8'(b)};
   endfunction

   // Work out the pixel pair that one taken word yields, and advance the frame position
   task automatic convert_word(input camera_word_type wd, output logic has_pair,
                               output rgb_pair_type pair);
      int w, h, total, n, cnt, valid, wpl, nxt;
      logic last;
      logic [23:0] p0, p1;
      w = (cfg_width == 0) ? 1 : ((int'(cfg_width) > MAX_WIDTH) ? MAX_WIDTH : int'(cfg_width));
      h = (cfg_height == 0) ? 1 :
          ((int'(cfg_height) > MAX_HEIGHT) ? MAX_HEIGHT : int'(cfg_height));
      pair = '0;
      has_pair = 1'b0;
      if (cfg_fmt == FMT_RGB565) begin
         total = w * h;
         cnt = int'(pix_count);
         n = wd.only_low_half ? 1 : 2;
         if (cnt >= total) cnt = 0;
         // Near the frame end only the pixels that remain are produced
         if (n > total - cnt) n = total - cnt;
         p0 = rgb565_to_rgb(wd.byte0, wd.byte1);
         p1 = (n == 2) ? rgb565_to_rgb(wd.byte2, wd.byte3) : 24'd0;
         cnt = cnt + n;
         {pair.red0, pair.green0, pair.blue0} = p0;
         {pair.red1, pair.green1, pair.blue1} = p1;
         pair.pixels_valid = (n == 2) ? PIX_TWO : PIX_ONE;
         if (cnt >= total) begin
            pair.last_of_frame = 1'b1;
            cnt = 0;
         end
         pix_count = PC_W'(cnt);
         has_pair = 1'b1;
      end else if (cfg_fmt == FMT_YUYV || cfg_fmt == FMT_UYVY) begin
         valid = w / 2;
         wpl = int'(cfg_stride) >> 2;
         if (wpl < valid) wpl = valid;
         if (wpl < 1) wpl = 1;
         if (wpl > WORDS_CAP) wpl = WORDS_CAP;
         if (int'(word_pos) >= wpl) word_pos = '0;
         if (int'(line_pos) >= h) line_pos = '0;
         // Words past width/2 are line padding and give nothing
         if (int'(word_pos) < valid) begin
            last = (int'(line_pos) == h - 1) && (int'(word_pos) == valid - 1);
            if (cfg_fmt == FMT_YUYV) begin
               p0 = bt601_pixel(wd.byte0, wd.byte1, wd.byte3);
               p1 = bt601_pixel(wd.byte2, wd.byte1, wd.byte3);
            end else begin
               p0 = bt601_pixel(wd.byte1, wd.byte0, wd.byte2);
               p1 = bt601_pixel(wd.byte3, wd.byte0, wd.byte2);
            end
            {pair.red0, pair.green0, pair.blue0} = p0;
            {pair.red1, pair.green1, pair.blue1} = p1;
            pair.pixels_valid = PIX_TWO;
            pair.last_of_frame = last;
            has_pair = 1'b1;
         end
         nxt = int'(word_pos) + 1;
         if (nxt >= wpl) begin
            nxt = 0;
            if (int'(line_pos) + 1 >= h) line_pos = '0;
            else line_pos = line_pos + 1'b1;
         end
         word_pos = WIL_W'(nxt);
      end
      // The unused format ignores the word entirely
   endtask

   task automatic report_mismatch(input string what, input int got, input int want);
      if (error_count < PRINT_CAP) begin
         $display("[%0t] result %0d: %s got %0d, expected %0d",
                  $realtime, results_checked, what, got, want);
      end
      error_count++;
   endtask

   // Sender: offer one word at a time from the pending queue, with random gaps.
   // Hold the word until it is taken; advance only after the handshake.
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_took) begin
         if (send_gap > 0) begin
            send_gap--;
            req_valid <= 1'b0;
         end else if (pending_words.size() > 0) begin
            next_word = pending_words.pop_front();
            req_byte0 <= next_word.byte0;
            req_byte1 <= next_word.byte1;
            req_byte2 <= next_word.byte2;
            req_byte3 <= next_word.byte3;
            req_only_low_half <= next_word.only_low_half;
            req_valid <= 1'b1;
            send_gap = quiet_window ? 0 : pick_gap();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Receiver: stall at random, and once hold off long enough to fill the block
   // so that it has to stall its input while the sender keeps offering words.
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (!pressure_done && pressure_go) begin
            pressure_done = 1'b1;
            rsp_hold = PRESSURE_LEN;
         end else if (rsp_hold == 0 && !quiet_window && $urandom_range(0, 3) == 0) begin
            rsp_hold = pick_gap();
         end
         if (rsp_hold > 0) begin
            rsp_hold--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // Monitor: check results first, then update the predictor from register
   // writes and taken words, so each result is held against words taken before it.
   always @(posedge clock) begin
      if (reset) begin
         req_took <= 1'b0;
      end else begin
         req_took <= req_valid && req_ready;

         if (rsp_valid && rsp_ready) begin
            got_pair = '{rsp_red0, rsp_green0, rsp_blue0, rsp_red1, rsp_green1, rsp_blue1,
                         rsp_pixels_valid, rsp_last_of_frame};
            if (expected_pairs.size() == 0) begin
               report_mismatch("unexpected word, pixels_valid", got_pair.pixels_valid, 0);
            end else begin
               want_pair = expected_pairs.pop_front();
               if (got_pair.red0 !== want_pair.red0)
                  report_mismatch("red0", got_pair.red0, want_pair.red0);
               if (got_pair.green0 !== want_pair.green0)
                  report_mismatch("green0", got_pair.green0, want_pair.green0);
               if (got_pair.blue0 !== want_pair.blue0)
                  report_mismatch("blue0", got_pair.blue0, want_pair.blue0);
               if (got_pair.red1 !== want_pair.red1)
                  report_mismatch("red1", got_pair.red1, want_pair.red1);
               if (got_pair.green1 !== want_pair.green1)
                  report_mismatch("green1", got_pair.green1, want_pair.green1);
               if (got_pair.blue1 !== want_pair.blue1)
                  report_mismatch("blue1", got_pair.blue1, want_pair.blue1);
               if (got_pair.pixels_valid !== want_pair.pixels_valid)
                  report_mismatch("pixels_valid", got_pair.pixels_valid,
                                  want_pair.pixels_valid);
               if (got_pair.last_of_frame !== want_pair.last_of_frame)
                  report_mismatch("last_of_frame", got_pair.last_of_frame,
                                  want_pair.last_of_frame);
               if (want_pair.last_of_frame) frame_ends++;
            end
            results_checked++;
         end

         // Any register write restarts the frame counters
         if (csr_write_enable) begin
            case (csr_index)
               CSR_PIXEL_FORMAT: cfg_fmt    = csr_wdata[1:0];
               CSR_FRAME_WIDTH:  cfg_width  = csr_wdata[DIM_W-1:0];
               CSR_FRAME_HEIGHT: cfg_height = csr_wdata[DIM_W-1:0];
               CSR_LINE_STRIDE:  cfg_stride = csr_wdata[STRIDE_W-1:0];
               default: ;
            endcase
            word_pos  = '0;
            line_pos  = '0;
            pix_count = '0;
         end

         if (req_valid && req_ready) begin
            words_taken++;
            taken_word = '{req_byte0, req_byte1, req_byte2, req_byte3, req_only_low_half};
            convert_word(taken_word, produced, made_pair);
            if (produced) expected_pairs.push_back(made_pair);
         end
      end
   end

   task automatic add_word(input logic [7:0] b0, b1, b2, b3, input logic olh);
      pending_words.push_back(camera_word_type'{b0, b1, b2, b3, olh});
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_W-1:0] data);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
   endtask

   // Write the registers picked by the mask, one per cycle, then drop the enable
   task automatic program_config(input logic [3:0] mask, input logic [CSR_W-1:0] fmt,
                                 input logic [CSR_W-1:0] width, height, stride);
      if (mask[0]) write_reg(CSR_PIXEL_FORMAT, fmt);
      if (mask[1]) write_reg(CSR_FRAME_WIDTH, width);
      if (mask[2]) write_reg(CSR_FRAME_HEIGHT, height);
      if (mask[3]) write_reg(CSR_LINE_STRIDE, stride);
      @(negedge clock);
      csr_write_enable <= 1'b0;
      settings_count++;
   endtask

   // Wait until every word is taken and every result is in, then let the
   // block idle for DRAIN_CYCLES.
   task automatic wait_idle();
      while (pending_words.size() > 0 || req_valid || expected_pairs.size() > 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   initial begin
      logic [CSR_W-1:0] fmt_data, width_data, height_data, stride_data;
      logic [3:0]       mask;
      int               random_count, count;

      random_count = 0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Reset settings: RGB565, 1024x600. Extremes, pure red and green, single pixel.
      add_word(8'h00, 8'h00, 8'h00, 8'h00, 1'b0);
      add_word(8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b0);
      add_word(8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1);
      add_word(8'h00, 8'hF8, 8'hE0, 8'h07, 1'b0);
      add_word(8'h1F, 8'h00, 8'h55, 8'hAA, 1'b0);
      wait_idle();

      // Long receiver hold-off while the sender keeps offering RGB565 words
      pressure_go = 1'b1;
      repeat (PRESSURE_WORDS) pending_words.push_back(random_word());
      wait_idle();

      // RGB565 frame of three pixels: second word straddles the end, gives one pixel
      program_config(ALL_REGS, CSR_W'(FMT_RGB565), 15'd3, 15'd1, 15'd4);
      add_word(8'h12, 8'h34, 8'h56, 8'h78, 1'b0);
      add_word(8'h9A, 8'hBC, 8'hDE, 8'hF0, 1'b0);
      add_word(8'hFF, 8'h00, 8'h00, 8'hFF, 1'b0);
      wait_idle();

      // YUYV odd width: last pixel of each line dropped; stride raised to width/2
      program_config(ALL_REGS, CSR_W'(FMT_YUYV), 15'd5, 15'd2, 15'd4);
      add_word(8'h00, 8'h00, 8'h00, 8'h00, 1'b1);
      add_word(8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b0);
      add_word(8'h10, 8'h80, 8'hEB, 8'h80, 1'b0);
      add_word(8'hFF, 8'h00, 8'hFF, 8'hFF, 1'b1);
      wait_idle();

      // UYVY with line padding: two pixel words, two padding words, then a new frame
      program_config(ALL_REGS, CSR_W'(FMT_UYVY), 15'd4, 15'd1, 15'd16);
      add_word(8'h00, 8'hFF, 8'hFF, 8'h00, 1'b0);
      add_word(8'hFF, 8'h00, 8'h00, 8'hFF, 1'b0);
      add_word(8'h11, 8'h22, 8'h33, 8'h44, 1'b0);
      add_word(8'h55, 8'h66, 8'h77, 8'h88, 1'b0);
      add_word(8'h80, 8'h10, 8'h80, 8'hEB, 1'b0);
      wait_idle();

      // Width one in YUV: every word is padding
      program_config(4'b0011, CSR_W'(FMT_YUYV), 15'd1, 15'd0, 15'd0);
      add_word(8'hAB, 8'hCD, 8'hEF, 8'h01, 1'b0);
      add_word(8'h23, 8'h45, 8'h67, 8'h89, 1'b1);
      wait_idle();

      // Unused format: words are ignored
      program_config(4'b0001, CSR_W'(FMT_UNUSED), 15'd0, 15'd0, 15'd0);
      add_word(8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b0);
      add_word(8'h00, 8'h00, 8'h00, 8'h00, 1'b1);
      wait_idle();

      // Zero dimensions clamp to one pixel per frame
      program_config(ALL_REGS, CSR_W'(FMT_RGB565), 15'd0, 15'd0, 15'd0);
      add_word(8'hE0, 8'h07, 8'h1F, 8'hF8, 1'b0);
      add_word(8'h1F, 8'hF8, 8'hE0, 8'h07, 1'b0);
      wait_idle();

      // Oversized dimensions and stride clamp to the caps
      program_config(ALL_REGS, CSR_W'(FMT_YUYV), 15'h7FFF, 15'h7FFF, 15'h7FFF);
      add_word(8'hEB, 8'hF0, 8'h10, 8'h10, 1'b0);
      add_word(8'h10, 8'h10, 8'hEB, 8'hF0, 1'b0);
      add_word(8'h7F, 8'h80, 8'h81, 8'h7E, 1'b1);
      wait_idle();

      // Random settings, mostly small frames so that frame ends come often
      while (random_count < RANDOM_WORDS) begin
         fmt_data = ($urandom_range(0, 15) == 0) ? CSR_W'(FMT_UNUSED)
                                                 : CSR_W'($urandom_range(0, 2));
         if ($urandom_range(0, 7) == 0) fmt_data[CSR_W-1:2] = (CSR_W - 2)'($urandom);
         case ($urandom_range(0, 11))
            0: width_data = 15'd0;
            1: width_data = 15'd4096;
            2: width_data = 15'h1FFF;
            3: width_data = 15'd2;
            default: width_data = CSR_W'($urandom_range(1, 12));
         endcase
         case ($urandom_range(0, 11))
            0: height_data = 15'd0;
            1: height_data = 15'd4096;
            2: height_data = 15'h1FFF;
            default: height_data = CSR_W'($urandom_range(1, 4));
         endcase
         if ($urandom_range(0, 7) == 0) begin
            width_data[CSR_W-1:DIM_W] = 2'($urandom);
            height_data[CSR_W-1:DIM_W] = 2'($urandom);
         end
         case ($urandom_range(0, 9))
            0: stride_data = 15'd0;
            1: stride_data = 15'd4;
            2: stride_data = 15'd16384;
            3: stride_data = 15'h7FFF;
            default: stride_data = CSR_W'($urandom_range(0, 40));
         endcase
         // Sometimes change only some registers, restarting mid-frame
         mask = ($urandom_range(0, 4) == 0) ? 4'($urandom_range(1, 15)) : ALL_REGS;
         program_config(mask, fmt_data, width_data, height_data, stride_data);

         if (cfg_fmt == FMT_UNUSED) begin
            count = 4;
         end else begin
            count = $urandom_range(24, 90);
            random_count += count;
         end
         repeat (count) pending_words.push_back(random_word());
         wait_idle();
      end

      $display("Covered %0d words over %0d register settings in RGB565, YUYV, UYVY and unused",
               words_taken, settings_count);
      $display("formats; %0d results checked, %0d frame ends, long receiver hold-off %s.",
               results_checked, frame_ends, pressure_done ? "done" : "not reached");
      if (error_count == 0) begin
         $display("tb_camera_pixel_to_rgb888: PASS");
      end else begin
         $display("tb_camera_pixel_to_rgb888: FAIL");
      end
      $finish;
   end

endmodule

@@ camera_pixel_to_rgb888.f @@
rtl/cp2rgb_pkg.sv
rtl/cp2rgb_front.sv
rtl/cp2rgb_queue.sv
rtl/cp2rgb_back.sv
rtl/camera_pixel_to_rgb888.sv
tb/tb_camera_pixel_to_rgb888.sv
